// ===== design/assert_macros.svh =====
// Assertion macros for the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_IMPLY(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("implication failed");
`define CHK_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("next-cycle check failed");
`else
`define CHK_IMPLY(lbl, clk, rstn, a, c)
`define CHK_NEXT(lbl, clk, rstn, a, c)
`endif
`endif

// ===== design/gvp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gvp_pkg;

    localparam int VIA_SHIFT_X_DEF = 0;
    localparam int VIA_SHIFT_Y_DEF = 0;
    localparam int VIA_SHIFT_Z_DEF = 0;

    localparam logic [2:0] REG_ROT_W   = 3'd0;
    localparam logic [2:0] REG_ROT_X   = 3'd1;
    localparam logic [2:0] REG_ROT_Y   = 3'd2;
    localparam logic [2:0] REG_ROT_Z   = 3'd3;
    localparam logic [2:0] REG_SHIFT_X = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y = 3'd5;
    localparam logic [2:0] REG_SHIFT_Z = 3'd6;
    localparam logic [2:0] REG_SPEED   = 3'd7;

    localparam logic KIND_GRASP = 1'b0;
    localparam logic KIND_VIA   = 1'b1;

    localparam logic signed [15:0] Q_ONE = 16'sd16384;

    typedef struct packed {
        logic signed [23:0] speed;
        logic signed [23:0] shift_z;
        logic signed [23:0] shift_y;
        logic signed [23:0] shift_x;
        logic signed [15:0] rot_z;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_w;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_w;
        logic signed [23:0] pos_z;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_x;
    } obj_t;

    typedef struct packed {
        logic [2:0][23:0] vel;
        logic [2:0][23:0] vpos;
        logic [2:0][23:0] gpos;
        logic [3:0][15:0] quat;
    } res_t;

    function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
        if (v > 36'sd8388607) begin
            return 24'sh7fffff;
        end else if (v < -36'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [15:0] qround(input logic signed [33:0] r);
        logic signed [33:0] t;
        t = (r + 34'sd8192) >>> 14;
        if (t > 34'sd16384) begin
            return 16'sd16384;
        end else if (t < -34'sd16384) begin
            return -16'sd16384;
        end
        return t[15:0];
    endfunction

    // products order: xx yy zz xy xz yz wx wy wz; result row-major, Q2.28
    function automatic logic [8:0][35:0] qmat(input logic [8:0][31:0] p);
        logic signed [35:0] one;
        logic signed [35:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        logic [8:0][35:0] m;
        one = 36'sh010000000;
        xx = 36'($signed(p[0]));
        yy = 36'($signed(p[1]));
        zz = 36'($signed(p[2]));
        xy = 36'($signed(p[3]));
        xz = 36'($signed(p[4]));
        yz = 36'($signed(p[5]));
        wx = 36'($signed(p[6]));
        wy = 36'($signed(p[7]));
        wz = 36'($signed(p[8]));
        m[0] = one - ((yy + zz) <<< 1);
        m[1] = (xy - wz) <<< 1;
        m[2] = (xz + wy) <<< 1;
        m[3] = (xy + wz) <<< 1;
        m[4] = one - ((xx + zz) <<< 1);
        m[5] = (yz - wx) <<< 1;
        m[6] = (xz - wy) <<< 1;
        m[7] = (yz + wx) <<< 1;
        m[8] = one - ((xx + yy) <<< 1);
        return m;
    endfunction

    function automatic logic [8:0][31:0] qprod(input logic [3:0][15:0] q);
        logic [8:0][31:0] p;
        p[0] = 32'($signed(q[1])) * 32'($signed(q[1]));
        p[1] = 32'($signed(q[2])) * 32'($signed(q[2]));
        p[2] = 32'($signed(q[3])) * 32'($signed(q[3]));
        p[3] = 32'($signed(q[1])) * 32'($signed(q[2]));
        p[4] = 32'($signed(q[1])) * 32'($signed(q[3]));
        p[5] = 32'($signed(q[2])) * 32'($signed(q[3]));
        p[6] = 32'($signed(q[0])) * 32'($signed(q[1]));
        p[7] = 32'($signed(q[0])) * 32'($signed(q[2]));
        p[8] = 32'($signed(q[0])) * 32'($signed(q[3]));
        return p;
    endfunction

    // base + round(sum of three Q2.28 x Q8.16 products), saturated
    function automatic logic signed [23:0] place(input logic signed [59:0] a,
                                                 input logic signed [59:0] b,
                                                 input logic signed [59:0] c,
                                                 input logic signed [23:0] base);
        logic signed [61:0] acc;
        logic signed [35:0] r;
        acc = 62'(a) + 62'(b) + 62'(c) + 62'sd134217728;
        r = 36'(acc >>> 28) + 36'(base);
        return sat24(r);
    endfunction

endpackage
`default_nettype wire

// ===== design/gvp_pose_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gvp_pose_pipe #(
    parameter int VIA_SHIFT_X = gvp_pkg::VIA_SHIFT_X_DEF,
    parameter int VIA_SHIFT_Y = gvp_pkg::VIA_SHIFT_Y_DEF,
    parameter int VIA_SHIFT_Z = gvp_pkg::VIA_SHIFT_Z_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire gvp_pkg::obj_t in_obj,
    input  wire gvp_pkg::cfg_t cfg,
    output logic               out_valid,
    output gvp_pkg::res_t      out_res
);
    localparam logic signed [23:0] VIA_X = 24'(VIA_SHIFT_X);
    localparam logic signed [23:0] VIA_Y = 24'(VIA_SHIFT_Y);
    localparam logic signed [23:0] VIA_Z = 24'(VIA_SHIFT_Z);

    logic [5:0] valid_reg;

    logic [3:0][15:0] q_in, r_cfg;
    logic [2:0][23:0] shift_v, via_v;

    // stage A
    logic [3:0][3:0][31:0] qp_reg;
    logic [8:0][31:0]      ap_reg;
    logic [2:0][23:0]      apos_reg;
    // stage B
    logic [3:0][15:0]      bq_reg;
    logic [8:0][35:0]      bm_reg;
    logic [2:0][23:0]      bpos_reg;
    // stage C
    logic [8:0][59:0]      cp_reg;
    logic [8:0][31:0]      cg_reg;
    logic [3:0][15:0]      cq_reg;
    logic [2:0][23:0]      cpos_reg;
    // stage D
    logic [8:0][35:0]      dm_reg;
    logic [2:0][23:0]      dgpos_reg;
    logic [3:0][15:0]      dq_reg;
    // stage E
    logic [8:0][59:0]      ep_reg;
    logic [2:0][59:0]      es_reg;
    logic [2:0][23:0]      egpos_reg;
    logic [3:0][15:0]      eq_reg;
    // stage F
    gvp_pkg::res_t         res_reg;

    logic [3:0][33:0] qsum;
    logic [2:0][31:0] vel_r;

    assign q_in    = {in_obj.quat_z, in_obj.quat_y, in_obj.quat_x, in_obj.quat_w};
    assign r_cfg   = {cfg.rot_z, cfg.rot_y, cfg.rot_x, cfg.rot_w};
    assign shift_v = {cfg.shift_z, cfg.shift_y, cfg.shift_x};
    assign via_v   = {VIA_Z, VIA_Y, VIA_X};

    always_comb begin
        qsum[0] = 34'($signed(qp_reg[0][0])) - 34'($signed(qp_reg[1][1]))
                - 34'($signed(qp_reg[2][2])) - 34'($signed(qp_reg[3][3]));
        qsum[1] = 34'($signed(qp_reg[0][1])) + 34'($signed(qp_reg[1][0]))
                + 34'($signed(qp_reg[2][3])) - 34'($signed(qp_reg[3][2]));
        qsum[2] = 34'($signed(qp_reg[0][2])) - 34'($signed(qp_reg[1][3]))
                + 34'($signed(qp_reg[2][0])) + 34'($signed(qp_reg[3][1]));
        qsum[3] = 34'($signed(qp_reg[0][3])) + 34'($signed(qp_reg[1][2]))
                - 34'($signed(qp_reg[2][1])) + 34'($signed(qp_reg[3][0]));
        for (int i = 0; i < 3; i++) begin
            vel_r[i] = 32'(($signed(es_reg[i]) + 60'sd134217728) >>> 28);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    qp_reg[i][j] <= 32'($signed(q_in[i])) * 32'($signed(r_cfg[j]));
                end
            end
            ap_reg   <= gvp_pkg::qprod(q_in);
            apos_reg <= {in_obj.pos_z, in_obj.pos_y, in_obj.pos_x};

            for (int i = 0; i < 4; i++) begin
                bq_reg[i] <= gvp_pkg::qround($signed(qsum[i]));
            end
            bm_reg   <= gvp_pkg::qmat(ap_reg);
            bpos_reg <= apos_reg;

            for (int k = 0; k < 9; k++) begin
                cp_reg[k] <= 60'($signed(bm_reg[k])) * 60'($signed(shift_v[k % 3]));
            end
            cg_reg   <= gvp_pkg::qprod(bq_reg);
            cq_reg   <= bq_reg;
            cpos_reg <= bpos_reg;

            for (int i = 0; i < 3; i++) begin
                dgpos_reg[i] <= gvp_pkg::place($signed(cp_reg[3*i]), $signed(cp_reg[3*i+1]),
                                               $signed(cp_reg[3*i+2]), $signed(cpos_reg[i]));
            end
            dm_reg <= gvp_pkg::qmat(cg_reg);
            dq_reg <= cq_reg;

            for (int k = 0; k < 9; k++) begin
                ep_reg[k] <= 60'($signed(dm_reg[k])) * 60'($signed(via_v[k % 3]));
            end
            for (int i = 0; i < 3; i++) begin
                es_reg[i] <= 60'($signed(dm_reg[3*i+2])) * 60'(cfg.speed);
            end
            egpos_reg <= dgpos_reg;
            eq_reg    <= dq_reg;

            for (int i = 0; i < 3; i++) begin
                res_reg.vpos[i] <= gvp_pkg::place($signed(ep_reg[3*i]), $signed(ep_reg[3*i+1]),
                                                  $signed(ep_reg[3*i+2]), $signed(egpos_reg[i]));
                res_reg.vel[i]  <= gvp_pkg::sat24(36'($signed(vel_r[i])));
            end
            res_reg.gpos <= egpos_reg;
            res_reg.quat <= eq_reg;
        end
    end

    assign out_valid = valid_reg[5];
    assign out_res   = res_reg;

endmodule
`default_nettype wire

// ===== design/grasp_via_pose_from_object.sv =====
// Each object pose gives its grasp result first and its via result as the next output transaction.
// Poses overlap in the pipeline; a new one is accepted only while the output is empty or a via result is taken.
// Six multiply/sum stages advance together; a stall at the output holds every stage.
// Reset (aresetn low, synchronous) empties the pipeline and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module grasp_via_pose_from_object #(
    parameter int VIA_SHIFT_X = gvp_pkg::VIA_SHIFT_X_DEF,
    parameter int VIA_SHIFT_Y = gvp_pkg::VIA_SHIFT_Y_DEF,
    parameter int VIA_SHIFT_Z = gvp_pkg::VIA_SHIFT_Z_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [23:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // obj_pos_x, obj_pos_y, obj_pos_z, obj_quat_w, obj_quat_x, obj_quat_y, obj_quat_z
    input  wire logic [135:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_pos_x/y/z, out_quat_w/x/y/z, out_vel_x/y/z
    output logic [207:0]      m_tdata,
    // pose_kind
    output logic              m_tuser,
    output logic              m_tlast
);
    gvp_pkg::cfg_t cfg_reg;
    logic          beat_reg;
    logic          en;
    logic          out_valid;
    gvp_pkg::res_t res;
    logic [2:0][23:0] vel_out, pos_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= gvp_pkg::cfg_t'({144'd0, gvp_pkg::Q_ONE});
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                gvp_pkg::REG_ROT_W:   cfg_reg.rot_w   <= cfg_wdata[15:0];
                gvp_pkg::REG_ROT_X:   cfg_reg.rot_x   <= cfg_wdata[15:0];
                gvp_pkg::REG_ROT_Y:   cfg_reg.rot_y   <= cfg_wdata[15:0];
                gvp_pkg::REG_ROT_Z:   cfg_reg.rot_z   <= cfg_wdata[15:0];
                gvp_pkg::REG_SHIFT_X: cfg_reg.shift_x <= cfg_wdata;
                gvp_pkg::REG_SHIFT_Y: cfg_reg.shift_y <= cfg_wdata;
                gvp_pkg::REG_SHIFT_Z: cfg_reg.shift_z <= cfg_wdata;
                gvp_pkg::REG_SPEED:   cfg_reg.speed   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en       = !out_valid || (m_tready && beat_reg == gvp_pkg::KIND_VIA);
    assign s_tready = en;

    gvp_pose_pipe #(
        .VIA_SHIFT_X(VIA_SHIFT_X),
        .VIA_SHIFT_Y(VIA_SHIFT_Y),
        .VIA_SHIFT_Z(VIA_SHIFT_Z)
    ) u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_obj   (gvp_pkg::obj_t'(s_tdata)),
        .cfg      (cfg_reg),
        .out_valid(out_valid),
        .out_res  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= gvp_pkg::KIND_GRASP;
        end else if (m_tvalid && m_tready) begin
            beat_reg <= !beat_reg;
        end
    end

    assign vel_out = (beat_reg == gvp_pkg::KIND_VIA) ? res.vel : '0;
    assign pos_out = (beat_reg == gvp_pkg::KIND_VIA) ? res.vpos : res.gpos;

    assign m_tvalid = out_valid;
    assign m_tuser  = beat_reg;
    assign m_tlast  = beat_reg;
    assign m_tdata  = {vel_out[2], vel_out[1], vel_out[0],
                       res.quat[3], res.quat[2], res.quat[1], res.quat[0],
                       pos_out[2], pos_out[1], pos_out[0]};

    `CHK_NEXT(a_via_follows, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast)
    `CHK_NEXT(a_quat_shared, aclk, aresetn, m_tvalid && m_tready && !m_tlast, $stable(m_tdata[135:72]))
    `CHK_IMPLY(a_accept_drain, aclk, aresetn, s_tvalid && s_tready, !m_tvalid || (m_tready && m_tlast))
    `CHK_IMPLY(a_grasp_no_vel, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[207:136] == '0)

endmodule
`default_nettype wire

// ===== tb/grasp_via_pose_from_object_tb.sv =====
`timescale 1ns / 1ps
module grasp_via_pose_from_object_tb;

    typedef struct {
        logic               kind;
        logic               last;
        logic signed [23:0] pos [3];
        logic signed [15:0] quat [4];
        logic signed [23:0] vel [3];
    } pose_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [23:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    // rotation quaternion w,x,y,z; shift x,y,z; approach speed
    longint rot [4];
    longint shift [3];
    longint speed;

    pose_t  pose_queue [$];
    int     mismatches = 0;
    bit     rx_stall_off = 1'b0;

    grasp_via_pose_from_object u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint rnd_half_up(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void rot_matrix(longint q [4], output longint m [9]);
        longint w, x, y, z, one;
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        one = longint'(1) <<< 28;
        m[0] = one - 2 * (y * y + z * z);
        m[1] = 2 * (x * y - w * z);
        m[2] = 2 * (x * z + w * y);
        m[3] = 2 * (x * y + w * z);
        m[4] = one - 2 * (x * x + z * z);
        m[5] = 2 * (y * z - w * x);
        m[6] = 2 * (x * z - w * y);
        m[7] = 2 * (y * z + w * x);
        m[8] = one - 2 * (x * x + y * y);
    endfunction

    function automatic void predict_poses(logic [135:0] d);
        longint p [3];
        longint q [4];
        longint g [4];
        longint r [4];
        longint m [9];
        longint gp [3];
        longint vp [3];
        longint via [3];
        pose_t  gr, vi;
        via = '{gvp_pkg::VIA_SHIFT_X_DEF, gvp_pkg::VIA_SHIFT_Y_DEF, gvp_pkg::VIA_SHIFT_Z_DEF};
        for (int i = 0; i < 3; i++) p[i] = longint'($signed(d[24*i +: 24]));
        for (int i = 0; i < 4; i++) q[i] = longint'($signed(d[72 + 16*i +: 16]));
        r[0] = q[0]*rot[0] - q[1]*rot[1] - q[2]*rot[2] - q[3]*rot[3];
        r[1] = q[0]*rot[1] + q[1]*rot[0] + q[2]*rot[3] - q[3]*rot[2];
        r[2] = q[0]*rot[2] - q[1]*rot[3] + q[2]*rot[0] + q[3]*rot[1];
        r[3] = q[0]*rot[3] + q[1]*rot[2] - q[2]*rot[1] + q[3]*rot[0];
        for (int i = 0; i < 4; i++) g[i] = clip(rnd_half_up(r[i], 14), -16384, 16384);
        rot_matrix(q, m);
        for (int i = 0; i < 3; i++)
            gp[i] = clip(p[i] + rnd_half_up(m[3*i]*shift[0] + m[3*i+1]*shift[1]
                         + m[3*i+2]*shift[2], 28), -8388608, 8388607);
        rot_matrix(g, m);
        gr.kind = gvp_pkg::KIND_GRASP; gr.last = 1'b0;
        vi.kind = gvp_pkg::KIND_VIA;   vi.last = 1'b1;
        for (int i = 0; i < 3; i++) begin
            vp[i] = clip(gp[i] + rnd_half_up(m[3*i]*via[0] + m[3*i+1]*via[1]
                         + m[3*i+2]*via[2], 28), -8388608, 8388607);
            gr.pos[i] = 24'(gp[i]);
            vi.pos[i] = 24'(vp[i]);
            gr.vel[i] = '0;
            vi.vel[i] = 24'(clip(rnd_half_up(speed * m[3*i+2], 28), -8388608, 8388607));
        end
        for (int i = 0; i < 4; i++) begin
            gr.quat[i] = 16'(g[i]);
            vi.quat[i] = 16'(g[i]);
        end
        pose_queue = {pose_queue, gr, vi};
    endfunction

    task automatic write_reg(logic [2:0] idx, longint v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v[23:0];
        if (idx <= gvp_pkg::REG_ROT_Z) rot[idx] = longint'($signed(v[15:0]));
        else if (idx == gvp_pkg::REG_SPEED) speed = longint'($signed(v[23:0]));
        else shift[idx - gvp_pkg::REG_SHIFT_X] = longint'($signed(v[23:0]));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pose(longint p [3], longint q [4], bit no_gap = 0);
        logic [135:0] d;
        int gap;
        for (int i = 0; i < 3; i++) d[24*i +: 24] = p[i][23:0];
        for (int i = 0; i < 4; i++) d[72 + 16*i +: 16] = q[i][15:0];
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        predict_poses(d);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pose_queue.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (12) @(posedge aclk);
    endtask

    function automatic longint rand_pos();
        return longint'($signed(24'($urandom)));
    endfunction

    function automatic longint rand_q(bit wild);
        if (wild) return longint'($signed(16'($urandom)));
        return longint'($urandom_range(0, 32768)) - 16384;
    endfunction

    // near-unit quaternion with random signs
    function automatic void rand_unit(ref longint q [4]);
        int k;
        k = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) q[i] = longint'($urandom_range(0, 9000)) - 4500;
        q[k] = ($urandom_range(0, 1) ? 16384 : -16384) + (q[k] > 0 ? -q[k] : q[k]) / 4;
    endfunction

    // result side
    initial begin
        pose_t  e;
        int     rx_wait;
        rx_wait = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pose_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transaction %h", m_tdata);
                end else begin
                    bit bad;
                    e = pose_queue.pop_front();
                    bad = (m_tuser !== e.kind) || (m_tlast !== e.last);
                    for (int i = 0; i < 3; i++) begin
                        bad |= m_tdata[24*i +: 24] !== e.pos[i];
                        bad |= m_tdata[136 + 24*i +: 24] !== e.vel[i];
                    end
                    for (int i = 0; i < 4; i++)
                        bad |= m_tdata[72 + 16*i +: 16] !== e.quat[i];
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: kind %b/%b last %b/%b",
                                     e.kind, m_tuser, e.last, m_tlast);
                            $display("  pos %0d %0d %0d / %0d %0d %0d",
                                     e.pos[0], e.pos[1], e.pos[2],
                                     $signed(m_tdata[23:0]), $signed(m_tdata[47:24]),
                                     $signed(m_tdata[71:48]));
                            $display("  quat %0d %0d %0d %0d / %h",
                                     e.quat[0], e.quat[1], e.quat[2], e.quat[3],
                                     m_tdata[135:72]);
                            $display("  vel %0d %0d %0d / %h",
                                     e.vel[0], e.vel[1], e.vel[2], m_tdata[207:136]);
                        end
                    end
                end
                rx_wait = rx_stall_off ? 0 : $urandom_range(0, 8);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    task automatic test_defaults();
        longint p [3];
        longint q [4];
        p = '{0, 0, 0};          q = '{16384, 0, 0, 0};        send_pose(p, q);
        p = '{8388607, 8388607, 8388607};   q = '{-16384, 0, 0, 0}; send_pose(p, q);
        p = '{-8388608, -8388608, -8388608}; q = '{0, 16384, 0, 0}; send_pose(p, q);
        p = '{65536, -65536, 12345}; q = '{0, 0, 16384, 0};        send_pose(p, q);
        p = '{1, -1, 0};         q = '{0, 0, 0, -16384};           send_pose(p, q);
        drain();
    endtask

    task automatic test_extremes();
        longint p [3];
        longint q [4];
        write_reg(gvp_pkg::REG_ROT_W, 11585); write_reg(gvp_pkg::REG_ROT_X, -11585);
        write_reg(gvp_pkg::REG_ROT_Y, 0);     write_reg(gvp_pkg::REG_ROT_Z, 0);
        write_reg(gvp_pkg::REG_SHIFT_X, 8388607); write_reg(gvp_pkg::REG_SHIFT_Y, -8388608);
        write_reg(gvp_pkg::REG_SHIFT_Z, 65536);   write_reg(gvp_pkg::REG_SPEED, 8388607);
        p = '{8388607, -8388608, 0}; q = '{16384, 16384, 16384, 16384}; send_pose(p, q);
        p = '{-8388608, 8388607, 0}; q = '{-16384, -16384, -16384, -16384}; send_pose(p, q);
        // codes beyond the Q1.14 range
        p = '{100, 200, 300}; q = '{32767, -32768, 32767, -32768}; send_pose(p, q);
        p = '{0, 0, 0};       q = '{-1, -1, -1, -1};              send_pose(p, q);
        p = '{0, 0, 0};       q = '{0, 0, 0, 0};                  send_pose(p, q);
        p = '{4095, 0, 0};    q = '{11585, 0, 11585, 0};          send_pose(p, q);
        drain();
        write_reg(gvp_pkg::REG_SPEED, -8388608);
        write_reg(gvp_pkg::REG_ROT_W, -16384); write_reg(gvp_pkg::REG_ROT_X, 16384);
        write_reg(gvp_pkg::REG_ROT_Y, -16384); write_reg(gvp_pkg::REG_ROT_Z, 16384);
        p = '{0, 0, 0}; q = '{16384, 0, 0, 0};              send_pose(p, q);
        p = '{-5, 5, 7}; q = '{0, 11585, -11585, 0};         send_pose(p, q);
        p = '{0, 0, 0}; q = '{32767, 32767, 32767, 32767};   send_pose(p, q);
        drain();
    endtask

    task automatic test_random(int n_items, bit back_to_back);
        longint p [3];
        longint q [4];
        for (int n = 0; n < n_items; n++) begin
            if (n % 150 == 0) begin
                drain();
                if ($urandom_range(0, 1)) begin
                    rand_unit(q);
                    for (int i = 0; i < 4; i++) write_reg(3'(i), q[i]);
                end else begin
                    for (int i = 0; i < 4; i++) write_reg(3'(i), rand_q($urandom_range(0, 9) == 0));
                end
                for (int i = 0; i < 3; i++)
                    write_reg(3'(gvp_pkg::REG_SHIFT_X + i), $urandom_range(0, 1) ? rand_pos()
                              : longint'($urandom_range(0, 400000)) - 200000);
                write_reg(gvp_pkg::REG_SPEED, rand_pos());
            end
            for (int i = 0; i < 3; i++)
                p[i] = $urandom_range(0, 3) == 0 ? rand_pos()
                       : longint'($urandom_range(0, 2000000)) - 1000000;
            if ($urandom_range(0, 4) != 0) rand_unit(q);
            else for (int i = 0; i < 4; i++) q[i] = rand_q($urandom_range(0, 2) == 0);
            send_pose(p, q, back_to_back);
        end
        drain();
    endtask

    initial begin
        rot = '{16384, 0, 0, 0};
        shift = '{0, 0, 0};
        speed = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_extremes();
        test_random(1200, 1'b0);
        rx_stall_off = 1'b1;
        test_random(300, 1'b1);
        if (mismatches == 0 && pose_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/gvp_pkg.sv
design/gvp_pose_pipe.sv
design/grasp_via_pose_from_object.sv
tb/grasp_via_pose_from_object_tb.sv
